// ===== rtl/core/cefc_pkg.sv =====
package cefc_pkg;

  // Slot record memory geometry
  localparam int unsigned SLOT_COUNT  = 5;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned STRAT_SLOT  = 4;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  // Register reset values
  localparam logic [10:0] FIRST_ID_RST = 11'd0;
  localparam logic [10:0] STRAT_ID_RST = 11'd4;
  localparam logic [3:0]  VERSION_RST  = 4'd0;
  localparam logic [31:0] TIMEOUT_RST  = 32'd1000;

  // CRC-8 (J1850 polynomial)
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_XOR  = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h1D;

  // Strategy frame limits
  localparam logic [1:0] STRAT_MODE_MAX = 2'd2;
  localparam logic [7:0] STRAT_LEVEL_MAX = 8'd100;

  // Minimum data length of a protected frame
  localparam logic [3:0] MIN_DLC = 4'd8;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_POWER = 3'd1,
    ST_EXTENDED  = 3'd2,
    ST_SHORT     = 3'd3,
    ST_VERSION   = 3'd4,
    ST_CRC       = 3'd5,
    ST_RANGE     = 3'd6,
    ST_QUERY     = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    REG_FIRST_ID = 2'd0,
    REG_STRAT_ID = 2'd1,
    REG_VERSION  = 2'd2,
    REG_TIMEOUT  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] first_power_id;
    logic [10:0] strategy_id;
    logic [3:0]  expected_version;
    logic [31:0] max_age_ms;
  } cfg_t;

  // Decoded request handed from the front end to the check stage
  typedef struct packed {
    logic        query;
    logic        ext;
    logic        short_frame;
    logic        hit;
    logic        is_strat;
    logic        version_ok;
    slot_t       slot;
    logic [10:0] can_id;
    logic [63:0] payload;
    logic [31:0] now_ms;
  } dec_t;

  // One entry of the slot record memory
  typedef struct packed {
    logic [3:0]  alive;
    logic [31:0] rx_time;
  } rec_t;

  // CRC over id high byte, id low byte and payload bytes 0..6, MSB first
  function automatic logic [7:0] crc8(input logic [71:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = CRC_INIT;
    for (int i = 71; i >= 0; i--) begin
      fb  = crc[7] ^ data[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return crc ^ CRC_XOR;
  endfunction

endpackage

// ===== rtl/core/cefc_in_if.sv =====
interface cefc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [10:0] can_id;
  logic        is_extended;
  logic [3:0]  data_length;
  logic [63:0] payload;
  logic [31:0] now_ms;

  modport source (
    output valid, mode, can_id, is_extended, data_length, payload, now_ms,
    input  ready
  );
  modport sink (
    input  valid, mode, can_id, is_extended, data_length, payload, now_ms,
    output ready
  );
endinterface

// ===== rtl/core/cefc_out_if.sv =====
interface cefc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic        sequence_error;
  logic        stale;
  logic [31:0] crc_errors;
  logic [31:0] version_errors;
  logic [31:0] sequence_errors;
  logic [31:0] malformed_total;

  modport source (
    output valid, status, slot, sequence_error, stale, crc_errors, version_errors,
           sequence_errors, malformed_total,
    input  ready
  );
  modport sink (
    input  valid, status, slot, sequence_error, stale, crc_errors, version_errors,
           sequence_errors, malformed_total,
    output ready
  );
endinterface

// ===== rtl/core/cefc_ram.sv =====
module cefc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/cefc_cfg.sv =====
module cefc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cefc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cefc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cefc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output cefc_pkg::cfg_t                   cfg
);

  cefc_pkg::cfg_t   cfg_r;
  cefc_pkg::reg_idx_e reg_idx;
  logic             wr_req;

  assign reg_idx = cefc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_req  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_power_id   <= cefc_pkg::FIRST_ID_RST;
      cfg_r.strategy_id      <= cefc_pkg::STRAT_ID_RST;
      cfg_r.expected_version <= cefc_pkg::VERSION_RST;
      cfg_r.max_age_ms       <= cefc_pkg::TIMEOUT_RST;
    end else if (wr_req) begin
      unique case (reg_idx)
        cefc_pkg::REG_FIRST_ID: cfg_r.first_power_id   <= pwdata[10:0];
        cefc_pkg::REG_STRAT_ID: cfg_r.strategy_id      <= pwdata[10:0];
        cefc_pkg::REG_VERSION:  cfg_r.expected_version <= pwdata[3:0];
        cefc_pkg::REG_TIMEOUT:  cfg_r.max_age_ms       <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      cefc_pkg::REG_FIRST_ID: prdata = {21'd0, cfg_r.first_power_id};
      cefc_pkg::REG_STRAT_ID: prdata = {21'd0, cfg_r.strategy_id};
      cefc_pkg::REG_VERSION:  prdata = {28'd0, cfg_r.expected_version};
      cefc_pkg::REG_TIMEOUT:  prdata = cfg_r.max_age_ms;
      default:                prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/cefc_decode.sv =====
module cefc_decode (
  cefc_in_if.sink          in_if,
  input  cefc_pkg::cfg_t   cfg,
  output cefc_pkg::dec_t   dec
);

  logic [10:0] id_off;
  logic        in_block;
  logic        is_strat;

  // Map the id onto the power block or the strategy slot
  assign id_off   = in_if.can_id - cfg.first_power_id;
  assign in_block = (in_if.can_id >= cfg.first_power_id) && (id_off <= 11'd3);
  assign is_strat = in_if.can_id == cfg.strategy_id;

  always_comb begin
    dec.query       = in_if.mode;
    dec.ext         = in_if.is_extended;
    dec.short_frame = in_if.data_length < cefc_pkg::MIN_DLC;
    dec.hit         = is_strat || in_block;
    dec.is_strat    = is_strat;
    dec.version_ok  = in_if.payload[63:60] == cfg.expected_version;
    // Strategy id wins over an overlapping block id
    dec.slot        = is_strat ? cefc_pkg::slot_t'(cefc_pkg::STRAT_SLOT)
                               : cefc_pkg::slot_t'(id_off[1:0]);
    dec.can_id      = in_if.can_id;
    dec.payload     = in_if.payload;
    dec.now_ms      = in_if.now_ms;
  end

endmodule

// ===== rtl/core/cefc_check.sv =====
module cefc_check #(
  parameter int unsigned REQUIRED_SLOTS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  output logic            in_ready,
  input  cefc_pkg::dec_t  dec,
  input  logic [31:0]     max_age_ms,
  cefc_out_if.source      out_if
);

  localparam int unsigned SLOTS  = cefc_pkg::SLOT_COUNT;
  localparam int unsigned QCOUNT = (REQUIRED_SLOTS < SLOTS) ? REQUIRED_SLOTS : SLOTS;
  localparam cefc_pkg::slot_t QLAST = cefc_pkg::slot_t'(QCOUNT - 1);
  localparam logic        REQ_BEYOND = (REQUIRED_SLOTS > SLOTS);
  localparam int unsigned REC_W  = $bits(cefc_pkg::rec_t);

  // Stage state
  logic                s1_valid_r;
  cefc_pkg::dec_t      s1_r;
  cefc_pkg::slot_t     q_idx_r;
  logic                q_stale_r;
  logic [SLOTS-1:0]    seen_r;

  // Forwarding of a write that collided with a read
  logic                fwd_r;
  cefc_pkg::rec_t      fwd_rec_r;

  // Output register and tallies
  logic                out_valid_r;
  cefc_pkg::status_e   out_status_r;
  cefc_pkg::slot_t     out_slot_r;
  logic                out_seq_r;
  logic                out_stale_r;
  logic [31:0]         crc_tally_r;
  logic [31:0]         ver_tally_r;
  logic [31:0]         seq_tally_r;
  logic [31:0]         mal_tally_r;

  // Memory port
  logic                rd_en;
  cefc_pkg::slot_t     rd_addr;
  logic [REC_W-1:0]    rd_data;
  logic                wr_en;
  cefc_pkg::slot_t     wr_addr;
  cefc_pkg::rec_t      wr_rec;

  // Stage logic
  cefc_pkg::rec_t      rec;
  logic [7:0]          crc_calc;
  logic                crc_ok;
  logic [3:0]          alive;
  logic [3:0]          alive_exp;
  logic [31:0]         age;
  logic                slot_stale;
  logic                q_done;
  logic                s1_done;
  logic                q_step;
  logic                adv;

  cefc_pkg::status_e   res_status;
  cefc_pkg::slot_t     res_slot;
  logic                res_seq;
  logic                res_stale;
  logic                pass;
  logic                inc_crc;
  logic                inc_ver;
  logic                inc_seq;
  logic                inc_mal;

  cefc_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slot record as seen by this stage
  assign rec       = fwd_r ? fwd_rec_r : cefc_pkg::rec_t'(rd_data);
  assign crc_calc  = cefc_pkg::crc8({5'd0, s1_r.can_id, s1_r.payload[63:8]});
  assign crc_ok    = s1_r.payload[7:0] == crc_calc;
  assign alive     = s1_r.payload[59:56];
  assign alive_exp = rec.alive + 4'd1;

  // Staleness of the slot currently read by a query
  assign age        = s1_r.now_ms - rec.rx_time;
  assign slot_stale = !seen_r[q_idx_r] || (age > max_age_ms);

  // Stage control
  assign q_done   = q_idx_r == QLAST;
  assign s1_done  = !s1_r.query || q_done;
  assign q_step   = s1_valid_r && s1_r.query && !q_done;
  assign adv      = s1_valid_r && s1_done && (!out_valid_r || out_if.ready);
  assign in_ready = !s1_valid_r || adv;

  // Result of the request in the stage
  always_comb begin
    res_status = cefc_pkg::ST_OK;
    res_slot   = '0;
    res_seq    = 1'b0;
    res_stale  = 1'b0;
    pass       = 1'b0;
    inc_crc    = 1'b0;
    inc_ver    = 1'b0;
    inc_seq    = 1'b0;
    inc_mal    = 1'b0;
    priority if (s1_r.query) begin
      res_status = cefc_pkg::ST_QUERY;
      res_stale  = q_stale_r || slot_stale;
    end else if (s1_r.ext) begin
      res_status = cefc_pkg::ST_EXTENDED;
    end else if (s1_r.short_frame) begin
      res_status = cefc_pkg::ST_SHORT;
      inc_mal    = 1'b1;
    end else if (!s1_r.hit) begin
      res_status = cefc_pkg::ST_NOT_POWER;
    end else if (!s1_r.version_ok) begin
      res_status = cefc_pkg::ST_VERSION;
      inc_ver    = 1'b1;
      inc_mal    = 1'b1;
    end else if (!crc_ok) begin
      res_status = cefc_pkg::ST_CRC;
      inc_crc    = 1'b1;
      inc_mal    = 1'b1;
    end else begin
      pass     = 1'b1;
      res_slot = s1_r.slot;
      // First frame of a slot skips the alive counter check
      if (seen_r[s1_r.slot] && (alive != alive_exp)) begin
        res_seq = 1'b1;
        inc_seq = 1'b1;
      end
      if (s1_r.is_strat && ((s1_r.payload[49:48] > cefc_pkg::STRAT_MODE_MAX) ||
                            (s1_r.payload[15:8] > cefc_pkg::STRAT_LEVEL_MAX))) begin
        res_status = cefc_pkg::ST_RANGE;
        res_slot   = '0;
        inc_mal    = 1'b1;
      end
    end
  end

  // Memory read: new request, or the next slot of a running query
  assign rd_en   = in_fire || q_step;
  assign rd_addr = in_fire ? (dec.query ? cefc_pkg::slot_t'(0) : dec.slot)
                           : cefc_pkg::slot_t'(q_idx_r + 3'd1);

  // Memory write-back of a power frame that passes the version and CRC checks
  assign wr_en          = adv && pass;
  assign wr_addr        = s1_r.slot;
  assign wr_rec.alive   = alive;
  assign wr_rec.rx_time = s1_r.now_ms;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      q_idx_r     <= '0;
      q_stale_r   <= 1'b0;
      seen_r      <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      crc_tally_r <= '0;
      ver_tally_r <= '0;
      seq_tally_r <= '0;
      mal_tally_r <= '0;
    end else begin
      // Advance the stage
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        q_idx_r    <= '0;
        q_stale_r  <= REQ_BEYOND;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end else if (q_step) begin
        q_idx_r   <= q_idx_r + 3'd1;
        q_stale_r <= q_stale_r || slot_stale;
      end

      // Track a read that returns data older than a same-cycle write
      if (rd_en) begin
        fwd_r <= wr_en && (wr_addr == rd_addr);
      end

      // Hand the result over and update tallies
      if (adv) begin
        out_valid_r <= 1'b1;
        crc_tally_r <= crc_tally_r + {31'd0, inc_crc};
        ver_tally_r <= ver_tally_r + {31'd0, inc_ver};
        seq_tally_r <= seq_tally_r + {31'd0, inc_seq};
        mal_tally_r <= mal_tally_r + {31'd0, inc_mal};
        if (pass) begin
          seen_r[s1_r.slot] <= 1'b1;
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= dec;
    end
    if (rd_en) begin
      fwd_rec_r <= wr_rec;
    end
    if (adv) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_seq_r    <= res_seq;
      out_stale_r  <= res_stale;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = out_status_r;
  assign out_if.slot            = out_slot_r;
  assign out_if.sequence_error  = out_seq_r;
  assign out_if.stale           = out_stale_r;
  assign out_if.crc_errors      = crc_tally_r;
  assign out_if.version_errors  = ver_tally_r;
  assign out_if.sequence_errors = seq_tally_r;
  assign out_if.malformed_total = mal_tally_r;

`ifndef SYNTHESIS
  a_qidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.query |-> q_idx_r <= QLAST)
    else $error("query slot index past last required slot");

  a_seen_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> seen_r[$past(wr_addr)])
    else $error("written slot not marked seen");

  a_fwd_capture: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en && (rd_addr == wr_addr) |=> fwd_r)
    else $error("read/write collision not forwarded");

  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == cefc_pkg::ST_QUERY) |-> !out_seq_r && (out_slot_r == '0))
    else $error("query result carries frame fields");
`endif

endmodule

// ===== rtl/core/can_e2e_frame_checker_top.sv =====
// CAN end-to-end frame checker. Each request is either a received frame (mode 0) or a
// staleness query (mode 1); each produces one result. Frames are screened (extended id,
// DLC below 8), mapped to slots 0..3 (four ids from first_power_id) or slot 4
// (strategy_id), then checked for version nibble, CRC-8 in byte 7 and a per-slot 4-bit
// alive counter; strategy frames are also range checked. Frames are taken one per clock
// unless the output stalls or a query occupies the check stage; each is checked after a
// registered read of its slot record. A query reads one slot record per cycle from the
// single read port of the slot record memory, min(REQUIRED_SLOTS, 5) records in all;
// required slots beyond slot 4 always read as stale. The output register lets a new
// request enter while the previous result waits. Seen bits are flip-flops cleared by
// reset, so there is no clearing pass. Configuration registers sit at byte addresses 0, 4,
// 8 and 12 and must only be written while the block is idle.
module can_e2e_frame_checker_top #(
  parameter int unsigned REQUIRED_SLOTS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cefc_in_if.sink                          in_if,
  cefc_out_if.source                       out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cefc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cefc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cefc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  cefc_pkg::cfg_t cfg;
  cefc_pkg::dec_t dec;
  logic           in_ready;
  logic           in_fire;

  assign in_if.ready = in_ready;
  assign in_fire     = in_if.valid && in_ready;

  cefc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cefc_decode u_decode (
    .in_if (in_if),
    .cfg   (cfg),
    .dec   (dec)
  );

  cefc_check #(
    .REQUIRED_SLOTS (REQUIRED_SLOTS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_ready   (in_ready),
    .dec        (dec),
    .max_age_ms (cfg.max_age_ms),
    .out_if     (out_if)
  );

endmodule

// ===== test/can_e2e_frame_checker_top_tb.sv =====
module can_e2e_frame_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cefc_pkg::*;

  localparam int unsigned REQUIRED_SLOTS = 4;
  localparam int unsigned NUM_SLOTS      = 5;
  localparam int unsigned PROTECTED_DLC  = 8;
  localparam int unsigned LEVEL_LIMIT    = 100;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned DIRECTED_ROWS  = 23;

  // How byte 7 of a directed frame is filled in
  typedef enum logic [1:0] {
    SEAL_RAW,
    SEAL_GOOD,
    SEAL_BAD
  } seal_e;

  typedef struct packed {
    logic        mode;
    logic [10:0] can_id;
    logic        ext;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [31:0] now;
  } frame_req_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic        seq_err;
    logic        stale;
    logic [31:0] crc_cnt;
    logic [31:0] ver_cnt;
    logic [31:0] seq_cnt;
    logic [31:0] bad_cnt;
  } verdict_t;

  typedef struct packed {
    logic        mode;
    logic [10:0] can_id;
    logic        ext;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [31:0] now;
    seal_e       seal;
    logic        typed;
    status_e     status;
    logic [2:0]  slot;
    logic        stale;
  } row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  cefc_in_if  in_ch ();
  cefc_out_if out_ch ();

  can_e2e_frame_checker_top #(
    .REQUIRED_SLOTS(REQUIRED_SLOTS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the checker state and its registers
  logic [10:0] first_id_cfg = 11'd0;
  logic [10:0] strat_id_cfg = 11'd4;
  logic [3:0]  version_cfg  = 4'd0;
  logic [31:0] timeout_cfg  = 32'd1000;
  logic [3:0]  alive_mem [NUM_SLOTS] = '{default: 4'd0};
  logic [31:0] rx_time [NUM_SLOTS]   = '{default: 32'd0};
  logic [4:0]  seen_mask   = '0;
  logic [31:0] crc_tally   = '0;
  logic [31:0] ver_tally   = '0;
  logic [31:0] seq_tally   = '0;
  logic [31:0] bad_tally   = '0;

  verdict_t    verdict_q [$];
  logic [31:0] clock_ms = 32'd200;
  int unsigned requests_sent;
  int unsigned queries_sent;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned mismatches;

  // Directed frames and queries, run under the reset register values
  row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b1, 11'd0,    1'b0, 4'd8,  64'h0,                   32'd0,    SEAL_RAW,  1'b1,
      ST_QUERY,     3'd0, 1'b1},
    '{1'b0, 11'd0,    1'b1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5,    SEAL_RAW,  1'b1,
      ST_EXTENDED,  3'd0, 1'b0},
    '{1'b0, 11'd0,    1'b0, 4'd7,  64'h0,                   32'd5,    SEAL_GOOD, 1'b1,
      ST_SHORT,     3'd0, 1'b0},
    '{1'b0, 11'd2047, 1'b0, 4'd0,  64'h0123_4567_89AB_CDEF, 32'd5,    SEAL_RAW,  1'b1,
      ST_SHORT,     3'd0, 1'b0},
    '{1'b0, 11'd5,    1'b0, 4'd8,  64'h0,                   32'd5,    SEAL_GOOD, 1'b1,
      ST_NOT_POWER, 3'd0, 1'b0},
    '{1'b0, 11'd2047, 1'b0, 4'd15, 64'h0,                   32'd5,    SEAL_GOOD, 1'b1,
      ST_NOT_POWER, 3'd0, 1'b0},
    '{1'b0, 11'd0,    1'b0, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 32'd5,    SEAL_RAW,  1'b1,
      ST_VERSION,   3'd0, 1'b0},
    '{1'b0, 11'd0,    1'b0, 4'd8,  64'h0011_2233_4455_6600, 32'd5,    SEAL_BAD,  1'b1,
      ST_CRC,       3'd0, 1'b0},
    '{1'b0, 11'd0,    1'b0, 4'd8,  64'h0,                   32'd10,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd0, 1'b0},
    '{1'b0, 11'd0,    1'b0, 4'd12, 64'h02A5_5AA5_5AA5_5A00, 32'd20,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd0, 1'b0},
    '{1'b0, 11'd0,    1'b0, 4'd8,  64'h0300_0000_0000_0000, 32'd30,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd0, 1'b0},
    '{1'b0, 11'd1,    1'b0, 4'd8,  64'h0F00_0000_0000_0000, 32'd40,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd1, 1'b0},
    '{1'b0, 11'd2,    1'b0, 4'd8,  64'h0700_0000_0000_0000, 32'd50,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd2, 1'b0},
    '{1'b0, 11'd3,    1'b0, 4'd8,  64'h0F00_0000_0000_0000, 32'd60,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd3, 1'b0},
    '{1'b0, 11'd3,    1'b0, 4'd8,  64'h0,                   32'd70,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd3, 1'b0},
    '{1'b1, 11'd0,    1'b0, 4'd8,  64'h0,                   32'd1030, SEAL_RAW,  1'b0,
      ST_QUERY,     3'd0, 1'b0},
    '{1'b1, 11'd0,    1'b0, 4'd8,  64'h0,                   32'd1031, SEAL_RAW,  1'b0,
      ST_QUERY,     3'd0, 1'b0},
    '{1'b0, 11'd4,    1'b0, 4'd8,  64'h0002_0000_0000_6400, 32'd80,   SEAL_GOOD, 1'b1,
      ST_OK,        3'd4, 1'b0},
    '{1'b0, 11'd4,    1'b0, 4'd8,  64'h0103_0000_0000_0000, 32'd90,   SEAL_GOOD, 1'b1,
      ST_RANGE,     3'd0, 1'b0},
    '{1'b0, 11'd4,    1'b0, 4'd8,  64'h0200_0000_0000_6500, 32'd100,  SEAL_GOOD, 1'b1,
      ST_RANGE,     3'd0, 1'b0},
    '{1'b0, 11'd4,    1'b0, 4'd8,  64'h03FF_FFFF_FFFF_FF00, 32'd110,  SEAL_GOOD, 1'b1,
      ST_RANGE,     3'd0, 1'b0},
    '{1'b1, 11'd2047, 1'b1, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, SEAL_RAW, 1'b0,
      ST_QUERY,     3'd0, 1'b0},
    '{1'b0, 11'd0,    1'b0, 4'd8,  64'h04FF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, SEAL_GOOD, 1'b1,
      ST_OK,        3'd0, 1'b0}
  };

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // SAE J1850 CRC-8 over id high byte, id low byte and payload bytes 0..6
  function automatic logic [7:0] j1850_crc(input logic [10:0] id, input logic [63:0] payload);
    logic [7:0] acc;
    logic [7:0] octet [9];
    octet[0] = {5'b0, id[10:8]};
    octet[1] = id[7:0];
    for (int i = 0; i < 7; i++) octet[i+2] = payload[63-8*i -: 8];
    acc = 8'hFF;
    for (int i = 0; i < 9; i++) begin
      acc ^= octet[i];
      for (int k = 0; k < 8; k++) begin
        acc = acc[7] ? ({acc[6:0], 1'b0} ^ 8'h1D) : {acc[6:0], 1'b0};
      end
    end
    return acc ^ 8'hFF;
  endfunction

  // Any required slot unseen or too old
  function automatic logic slots_stale(input logic [31:0] now);
    for (int s = 0; s < REQUIRED_SLOTS; s++) begin
      if (s >= NUM_SLOTS) return 1'b1;
      if (!seen_mask[s]) return 1'b1;
      if (32'(now - rx_time[s]) > timeout_cfg) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the result of one request and advance the shadow state
  function automatic verdict_t e2e_verdict(input frame_req_t r);
    verdict_t   v;
    int         rel;
    int         s;
    logic       strat_hit;
    logic       block_hit;
    logic [7:0] b0;
    v = '0;
    v.status = ST_OK;
    rel = int'(r.can_id) - int'(first_id_cfg);
    strat_hit = (r.can_id == strat_id_cfg);
    block_hit = (rel >= 0) && (rel <= 3);
    b0 = r.payload[63:56];
    if (r.mode) begin
      v.status = ST_QUERY;
      v.stale = slots_stale(r.now);
    end else if (r.ext) begin
      v.status = ST_EXTENDED;
    end else if (r.dlc < PROTECTED_DLC) begin
      v.status = ST_SHORT;
      bad_tally++;
    end else if (!strat_hit && !block_hit) begin
      v.status = ST_NOT_POWER;
    end else if (b0[7:4] != version_cfg) begin
      v.status = ST_VERSION;
      ver_tally++;
      bad_tally++;
    end else if (r.payload[7:0] != j1850_crc(r.can_id, r.payload)) begin
      v.status = ST_CRC;
      crc_tally++;
      bad_tally++;
    end else begin
      // strategy id wins over the block when both match
      s = strat_hit ? 4 : rel;
      if (seen_mask[s] && (b0[3:0] != 4'(alive_mem[s] + 1))) begin
        v.seq_err = 1'b1;
        seq_tally++;
      end
      alive_mem[s] = b0[3:0];
      seen_mask[s] = 1'b1;
      rx_time[s] = r.now;
      v.slot = 3'(s);
      if (strat_hit && (r.payload[49:48] > 2'd2 || r.payload[15:8] > LEVEL_LIMIT)) begin
        v.status = ST_RANGE;
        v.slot = 3'd0;
        bad_tally++;
      end
    end
    v.crc_cnt = crc_tally;
    v.ver_cnt = ver_tally;
    v.seq_cnt = seq_tally;
    v.bad_cnt = bad_tally;
    return v;
  endfunction

  // Idle cycles before the next request; some stretches run without idling
  function automatic int unsigned draw_wait();
    return ((requests_sent / 48) % 4 == 3) ? 0 : $urandom_range(0, 7);
  endfunction

  // Random request: mostly well-formed frames on the configured ids
  function automatic frame_req_t draw_request();
    frame_req_t  r;
    logic [7:0]  b [7];
    logic [3:0]  alive;
    logic [3:0]  ver;
    int          rel;
    int unsigned pick;
    int unsigned s;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick >= 30) clock_ms += $urandom_range(1, 300);
    r.now = clock_ms;
    r.mode = ($urandom_range(0, 99) < 12);
    r.ext = ($urandom_range(0, 99) < 4);
    r.dlc = ($urandom_range(0, 99) < 5) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
    pick = $urandom_range(0, 99);
    if (pick < 55) r.can_id = 11'(first_id_cfg + $urandom_range(0, 3));
    else if (pick < 75) r.can_id = strat_id_cfg;
    else if (pick < 85) r.can_id = pick[0] ? 11'(first_id_cfg - 1) : 11'(first_id_cfg + 4);
    else r.can_id = 11'($urandom);
    rel = int'(r.can_id) - int'(first_id_cfg);
    s = (r.can_id == strat_id_cfg) ? 4 : ((rel >= 0 && rel <= 3) ? rel : 0);
    alive = ($urandom_range(0, 99) < 80) ? 4'(alive_mem[s] + 1) : 4'($urandom);
    ver = ($urandom_range(0, 99) < 92) ? version_cfg : 4'($urandom);
    for (int i = 1; i < 7; i++) b[i] = 8'($urandom);
    if ($urandom_range(0, 99) < 85) b[6] = 8'($urandom_range(0, LEVEL_LIMIT));
    b[0] = {ver, alive};
    r.payload = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], 8'h00};
    r.payload[7:0] = j1850_crc(r.can_id, r.payload);
    if ($urandom_range(0, 99) >= 92) r.payload[7:0] ^= 8'($urandom_range(1, 255));
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at result %0d: %s", results_checked, what);
    mismatches++;
  endtask

  // Present one request, wait for the handshake, record its result
  task automatic push_request(input frame_req_t r, input logic typed, input status_e status,
                              input logic [2:0] slot, input logic stale);
    int unsigned gap;
    verdict_t    v;
    gap = draw_wait();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= r.mode;
    in_ch.can_id      <= r.can_id;
    in_ch.is_extended <= r.ext;
    in_ch.data_length <= r.dlc;
    in_ch.payload     <= r.payload;
    in_ch.now_ms      <= r.now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    v = e2e_verdict(r);
    if (typed) begin
      v.status = status;
      v.slot = slot;
      v.stale = stale;
    end
    verdict_q.push_back(v);
    requests_sent++;
    if (r.mode) queries_sent++;
  endtask

  // APB write, after which the bus is left idle
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FIRST_ID: first_id_cfg = value[10:0];
      REG_STRAT_ID: strat_id_cfg = value[10:0];
      REG_VERSION:  version_cfg  = value[3:0];
      REG_TIMEOUT:  timeout_cfg  = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // APB read, compared with the shadow register
  task automatic reg_readback(input reg_idx_e idx);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_FIRST_ID: want = 32'(first_id_cfg);
      REG_STRAT_ID: want = 32'(strat_id_cfg);
      REG_VERSION:  want = 32'(version_cfg);
      default:      want = timeout_cfg;
    endcase
    if (prdata !== want) begin
      report_mismatch($sformatf("register %s read %0h want %0h", idx.name(), prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic readback_all();
    reg_readback(REG_FIRST_ID);
    reg_readback(REG_STRAT_ID);
    reg_readback(REG_VERSION);
    reg_readback(REG_TIMEOUT);
  endtask

  // Pick a register setting: fixed corner cases first, then random ones
  task automatic apply_setting(input int unsigned phase);
    logic [10:0] first;
    logic [10:0] strat;
    logic [3:0]  ver;
    logic [31:0] tout;
    case (phase)
      // strategy id inside the block, near the top of the id space
      1: begin
        first = 11'd2044; strat = 11'd2046; ver = 4'd15; tout = 32'd0;
      end
      2: begin
        first = 11'd2047; strat = 11'd2047; ver = 4'd0; tout = 32'hFFFF_FFFF;
      end
      3: begin
        first = 11'd0; strat = 11'd0; ver = 4'd9; tout = 32'd1;
      end
      // block cut short at id 2047, must not wrap to 0
      4: begin
        first = 11'd2046; strat = 11'd3; ver = 4'd5; tout = 32'd1000;
      end
      default: begin
        first = 11'($urandom);
        strat = $urandom_range(0, 1) ? 11'(first + $urandom_range(0, 5)) : 11'($urandom);
        ver = 4'($urandom);
        tout = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
      end
    endcase
    reg_write(REG_FIRST_ID, 32'(first));
    reg_write(REG_STRAT_ID, 32'(strat));
    reg_write(REG_VERSION, 32'(ver));
    reg_write(REG_TIMEOUT, tout);
    readback_all();
    settings_used++;
  endtask

  // Wait until every pending result has come out, then let the block settle
  task automatic drain();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Reset, directed table, random phases, final verdict
  initial begin
    frame_req_t req;
    row_t       row;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.can_id = '0;
    in_ch.is_extended = 1'b0;
    in_ch.data_length = '0;
    in_ch.payload = '0;
    in_ch.now_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    readback_all();
    settings_used = 1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      req.mode = row.mode;
      req.can_id = row.can_id;
      req.ext = row.ext;
      req.dlc = row.dlc;
      req.now = row.now;
      req.payload = row.payload;
      case (row.seal)
        SEAL_GOOD: req.payload[7:0] = j1850_crc(row.can_id, row.payload);
        SEAL_BAD:  req.payload[7:0] = ~j1850_crc(row.can_id, row.payload);
        default: ;
      endcase
      push_request(req, row.typed, row.status, row.slot, row.stale);
    end
    in_ch.valid <= 1'b0;

    // Random requests under a series of register settings
    for (int unsigned phase = 1; phase <= PHASES; phase++) begin
      drain();
      apply_setting(phase);
      repeat (PHASE_ITEMS) push_request(draw_request(), 1'b0, ST_OK, 3'd0, 1'b0);
      in_ch.valid <= 1'b0;
    end
    drain();

    $display("Sent %0d requests (%0d queries, %0d directed) under %0d register settings",
             requests_sent, queries_sent, DIRECTED_ROWS, settings_used);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Accept results with random stalls and compare against the oldest prediction
  initial begin
    verdict_t want;
    int unsigned stall;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", out_ch.status, want.status));
        if (out_ch.slot !== want.slot)
          report_mismatch($sformatf("slot %0d want %0d", out_ch.slot, want.slot));
        if (out_ch.sequence_error !== want.seq_err)
          report_mismatch($sformatf("sequence_error %0b want %0b",
                                    out_ch.sequence_error, want.seq_err));
        if (out_ch.stale !== want.stale)
          report_mismatch($sformatf("stale %0b want %0b", out_ch.stale, want.stale));
        if (out_ch.crc_errors !== want.crc_cnt)
          report_mismatch($sformatf("crc_errors %0d want %0d", out_ch.crc_errors, want.crc_cnt));
        if (out_ch.version_errors !== want.ver_cnt)
          report_mismatch($sformatf("version_errors %0d want %0d",
                                    out_ch.version_errors, want.ver_cnt));
        if (out_ch.sequence_errors !== want.seq_cnt)
          report_mismatch($sformatf("sequence_errors %0d want %0d",
                                    out_ch.sequence_errors, want.seq_cnt));
        if (out_ch.malformed_total !== want.bad_cnt)
          report_mismatch($sformatf("malformed_total %0d want %0d",
                                    out_ch.malformed_total, want.bad_cnt));
      end
      results_checked++;
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Run did not finish in time, %0d results still pending", verdict_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cefc_pkg.sv
rtl/core/cefc_in_if.sv
rtl/core/cefc_out_if.sv
rtl/core/cefc_ram.sv
rtl/core/cefc_cfg.sv
rtl/core/cefc_decode.sv
rtl/core/cefc_check.sv
rtl/core/can_e2e_frame_checker_top.sv
test/can_e2e_frame_checker_top_tb.sv
